// ----- rtl/blpld_pkg.sv -----
// ----------------------------------------------------------------------------
// blpld_pkg
// Shared constants, register codes and bundle types for the long-press level
// detector.
// ----------------------------------------------------------------------------
package blpld_pkg;

	localparam int LEVELS      = 5;
	localparam int COUNT_WIDTH = 24;

	localparam int NUM_THRESH = 5;
	localparam int THR_W      = 24;
	localparam int DUR_W      = 24;
	localparam int GAP_W      = 16;
	localparam int CFG_W      = 24;
	localparam int IDX_W      = 3;
	localparam int THR_SEL_W  = $clog2(NUM_THRESH);
	localparam int USED_MAX   = (LEVELS < NUM_THRESH) ? LEVELS : NUM_THRESH;
	localparam int LVL_W      = $clog2(NUM_THRESH + 1);

	localparam int WIDE_W   = ((COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W) + 1;
	localparam int CAP_BITS = (COUNT_WIDTH < DUR_W) ? COUNT_WIDTH : DUR_W;
	localparam logic [WIDE_W-1:0] DUR_CAP = (WIDE_W'(1) << CAP_BITS) - WIDE_W'(1);

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [IDX_W-1:0] {
		IDX_ACTIVE_LEVEL   = 3'd0,
		IDX_LEVEL_COUNT    = 3'd1,
		IDX_THR_ONE        = 3'd2,
		IDX_THR_TWO        = 3'd3,
		IDX_THR_THREE      = 3'd4,
		IDX_THR_FOUR       = 3'd5,
		IDX_THR_FIVE       = 3'd6,
		IDX_ALARM_INTERVAL = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic                              active_level;
		logic [LVL_W-1:0]                  level_count;
		logic [NUM_THRESH-1:0][THR_W-1:0]  thr;
		logic [GAP_W-1:0]                  alarm_interval;
	} cfg_t;

	typedef struct packed {
		logic              long_beep;
		logic              short_beep;
		logic              max_reached;
		logic [LVL_W-1:0]  press_level;
		logic [DUR_W-1:0]  press_duration;
		logic              released;
		logic              pressed;
	} res_t;

endpackage

// ----- rtl/blpld_track.sv -----
// ----------------------------------------------------------------------------
// blpld_track
// Press tracking state: edge handling, elapsed count, level and max flag,
// release duration, and beep requests for one sample per step.
// ----------------------------------------------------------------------------
module blpld_track (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           pin,
	input  blpld_pkg::cfg_t cfg,
	output blpld_pkg::res_t res
);
	import blpld_pkg::*;

	logic                   held_q, held_d;
	logic                   timing_q, timing_d;
	logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
	logic [LVL_W-1:0]       level_q, level_d;
	logic                   max_q, max_d;
	logic [LVL_W-1:0]       announced_q, announced_d;
	logic [GAP_W-1:0]       gap_q, gap_d;

	logic                   pressed;
	logic                   released;
	logic                   upd;
	logic                   sbeep;
	logic                   lbeep;
	logic [GAP_W-1:0]       gap_inc;
	logic [LVL_W-1:0]       used;
	logic [LVL_W-1:0]       found;
	logic [WIDE_W-1:0]      dur_w;
	logic [DUR_W-1:0]       dur;

	assign pressed = (pin == cfg.active_level);
	assign gap_inc = (&gap_q) ? gap_q : gap_q + GAP_W'(1);
	assign used    = (cfg.level_count > LVL_W'(USED_MAX)) ? LVL_W'(USED_MAX)
	                                                        : cfg.level_count;
	assign dur_w   = WIDE_W'(elapsed_q) + WIDE_W'(1);

	always_comb begin
		held_d      = held_q;
		timing_d    = timing_q;
		elapsed_d   = elapsed_q;
		level_d     = level_q;
		max_d       = max_q;
		announced_d = announced_q;
		gap_d       = gap_inc;
		released    = 1'b0;
		dur         = '0;
		upd         = 1'b1;
		sbeep       = 1'b0;
		lbeep       = 1'b0;

		if (pressed && !held_q) begin
			held_d    = 1'b1;
			timing_d  = 1'b1;
			elapsed_d = '0;
			level_d   = '0;
			max_d     = 1'b0;
		end else if (pressed && held_q) begin
			if (timing_q && !(&elapsed_q))
				elapsed_d = elapsed_q + COUNT_WIDTH'(1);
		end else if (!pressed && held_q) begin
			held_d = 1'b0;
			if (timing_q) begin
				dur      = (dur_w > DUR_CAP) ? DUR_W'(DUR_CAP) : DUR_W'(dur_w);
				released = 1'b1;
				timing_d = 1'b0;
				upd      = 1'b0;
			end
		end

		found = '0;
		for (int i = 1; i <= USED_MAX; i++) begin
			if ((LVL_W'(i) <= used) && (WIDE_W'(elapsed_d) >= WIDE_W'(cfg.thr[i-1])))
				found = LVL_W'(i);
		end

		if (upd && held_d && timing_d) begin
			if (found > level_d)
				level_d = found;
			if (level_d == used)
				max_d = 1'b1;
		end

		if (held_d) begin
			if (level_d != '0) begin
				if (level_d != announced_q) begin
					sbeep       = 1'b1;
					announced_d = level_d;
				end
				if (max_d && (gap_inc >= cfg.alarm_interval)) begin
					lbeep = 1'b1;
					gap_d = '0;
				end
			end
		end else begin
			announced_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			timing_q    <= 1'b0;
			elapsed_q   <= '0;
			level_q     <= '0;
			max_q       <= 1'b0;
			announced_q <= '0;
			gap_q       <= '1;
		end else if (step) begin
			held_q      <= held_d;
			timing_q    <= timing_d;
			elapsed_q   <= elapsed_d;
			level_q     <= level_d;
			max_q       <= max_d;
			announced_q <= announced_d;
			gap_q       <= gap_d;
		end
	end

	assign res.pressed        = pressed;
	assign res.released       = released;
	assign res.press_duration = dur;
	assign res.press_level    = level_d;
	assign res.max_reached    = max_d;
	assign res.short_beep     = sbeep;
	assign res.long_beep      = lbeep;

endmodule

// ----- rtl/button_long_press_level_detector.sv -----
// ----------------------------------------------------------------------------
// button_long_press_level_detector
// Button long-press level detector, one pin sample per beat.
//
// Each input beat carries one pin sample (one millisecond tick) and produces
// exactly one result beat. The block takes one beat per clock cycle while the
// result side does not stall. Each sample is held in the input register, runs
// through the press-tracking logic and is held in the result register, from
// which it is presented. A stalled result holds in the result register while
// the input register still takes one more beat. The user must write the
// configuration registers through cfg_we/cfg_index/cfg_wdata only while no
// beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_long_press_level_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [blpld_pkg::IN_TDATA_W-1:0]     s_tdata,  // [0] pin_level
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [0] pressed, [1] released, [25:2] press_duration, [28:26] press_level,
	// [29] max_reached, [30] short_beep, [31] long_beep
	output logic [blpld_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                 cfg_we,
	input  logic [blpld_pkg::IDX_W-1:0]          cfg_index,
	input  logic [blpld_pkg::CFG_W-1:0]          cfg_wdata
);
	import blpld_pkg::*;

	cfg_t                 cfg_q;
	logic                 vld_s1;
	logic                 pin_s1;
	logic                 vld_s2;
	res_t                 res_s2;
	res_t                 track_res;
	logic                 adv;
	logic                 step;
	logic [THR_SEL_W-1:0] thr_sel;

	assign adv      = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign step     = vld_s1 && adv;
	assign thr_sel  = THR_SEL_W'(cfg_index - IDX_THR_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level   <= 1'b0;
			cfg_q.level_count    <= LVL_W'(5);
			cfg_q.thr[0]         <= THR_W'(50);
			cfg_q.thr[1]         <= THR_W'(1000);
			cfg_q.thr[2]         <= THR_W'(2000);
			cfg_q.thr[3]         <= THR_W'(5000);
			cfg_q.thr[4]         <= THR_W'(10000);
			cfg_q.alarm_interval <= GAP_W'(2000);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				IDX_ACTIVE_LEVEL:   cfg_q.active_level   <= cfg_wdata[0];
				IDX_LEVEL_COUNT:    cfg_q.level_count    <= cfg_wdata[LVL_W-1:0];
				IDX_THR_ONE, IDX_THR_TWO, IDX_THR_THREE, IDX_THR_FOUR,
				IDX_THR_FIVE:       cfg_q.thr[thr_sel]   <= cfg_wdata[THR_W-1:0];
				IDX_ALARM_INTERVAL: cfg_q.alarm_interval <= cfg_wdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (adv)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			pin_s1 <= s_tdata[0];
		if (step)
			res_s2 <= track_res;
	end

	blpld_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pin    (pin_s1),
		.cfg    (cfg_q),
		.res    (track_res)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {res_s2.long_beep, res_s2.short_beep, res_s2.max_reached,
	                   res_s2.press_level, res_s2.press_duration, res_s2.released,
	                   res_s2.pressed};

	a_rel_not_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.released) |-> !res_s2.pressed)
		else $error("release reported while pressed");

	a_long_needs_max: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.long_beep) |-> (res_s2.max_reached && res_s2.pressed))
		else $error("long beep without max level held");

	a_short_needs_level: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.short_beep) |-> (res_s2.press_level != '0))
		else $error("short beep at level zero");

	a_dur_only_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !res_s2.released) |-> (res_s2.press_duration == '0))
		else $error("duration without release");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are full");

endmodule

// ----- tb/button_long_press_level_detector_tb.sv -----
// ----------------------------------------------------------------------------
// button_long_press_level_detector_tb
// Self-checking bench for the long-press level detector.
//
// A clocked driver feeds pin samples from a queue and a clocked monitor
// checks every result beat, field by field, against an in-bench model of the
// press timer, level tracker and beep logic. Phases change the register
// settings while the block is idle and vary the idling of both sides.
// ----------------------------------------------------------------------------
module button_long_press_level_detector_tb;
	import blpld_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [0] pin_level
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [0] pressed, [1] released, [25:2] press_duration, [28:26] press_level,
	// [29] max_reached, [30] short_beep, [31] long_beep
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;

	button_long_press_level_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// register copies
	logic             act_cfg = 1'b0;
	logic [2:0]       lvl_count_cfg = 3'd5;
	logic [THR_W-1:0] thr_cfg [NUM_THRESH] = '{24'd50, 24'd1000, 24'd2000, 24'd5000, 24'd10000};
	logic [GAP_W-1:0] alarm_cfg = 16'd2000;

	// press tracker state
	logic             held = 1'b0;
	logic             timing = 1'b0;
	logic [DUR_W-1:0] elapsed = '0;
	logic [2:0]       level_now = '0;
	logic             max_flag = 1'b0;
	logic [2:0]       announced = '0;
	logic [GAP_W-1:0] alarm_gap = '1;

	logic         pin_samples [$];
	res_t         expected_ticks [$];
	int unsigned  errors = 0;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  hold_reqs = 0;
	int unsigned  hold_seen = 0;
	int unsigned  hold_left = 0;
	logic         in_taken = 1'b0;

	function automatic res_t tick_button(input logic pin);
		res_t        r;
		logic        upd;
		logic [2:0]  n;
		logic [2:0]  lvl;
		logic        found;
		logic [DUR_W:0] dur;
		r = '0;
		upd = 1'b1;
		r.pressed = (pin == act_cfg);
		if (alarm_gap != '1)
			alarm_gap = alarm_gap + GAP_W'(1);
		if (r.pressed && !held) begin
			held = 1'b1;
			timing = 1'b1;
			elapsed = '0;
			level_now = '0;
			max_flag = 1'b0;
		end else if (r.pressed && held) begin
			if (timing && elapsed != '1)
				elapsed = elapsed + DUR_W'(1);
		end else if (!r.pressed && held) begin
			held = 1'b0;
			if (timing) begin
				dur = {1'b0, elapsed} + (DUR_W + 1)'(1);
				r.press_duration = dur[DUR_W] ? '1 : dur[DUR_W-1:0];
				r.released = 1'b1;
				timing = 1'b0;
				upd = 1'b0;
			end
		end
		if (upd && held && timing) begin
			n = (lvl_count_cfg > 3'(USED_MAX)) ? 3'(USED_MAX) : lvl_count_cfg;
			lvl = '0;
			found = 1'b0;
			for (int i = USED_MAX; i >= 1; i--) begin
				if (!found && 3'(i) <= n && elapsed >= thr_cfg[i-1]) begin
					lvl = 3'(i);
					found = 1'b1;
				end
			end
			if (lvl > level_now)
				level_now = lvl;
			if (level_now == n)
				max_flag = 1'b1;
		end
		if (held) begin
			if (level_now != '0) begin
				if (level_now != announced) begin
					r.short_beep = 1'b1;
					announced = level_now;
				end
				if (max_flag && alarm_gap >= alarm_cfg) begin
					r.long_beep = 1'b1;
					alarm_gap = '0;
				end
			end
		end else begin
			announced = '0;
		end
		r.press_level = level_now;
		r.max_reached = max_flag;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// result monitor and input predictor
	always @(posedge clk) begin
		res_t got;
		res_t want;
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (expected_ticks.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, m_tdata);
					errors++;
				end else begin
					want = expected_ticks.pop_front();
					check_field("pressed", 32'(want.pressed), 32'(got.pressed));
					check_field("released", 32'(want.released), 32'(got.released));
					check_field("press_duration", 32'(want.press_duration),
						32'(got.press_duration));
					check_field("press_level", 32'(want.press_level),
						32'(got.press_level));
					check_field("max_reached", 32'(want.max_reached),
						32'(got.max_reached));
					check_field("short_beep", 32'(want.short_beep), 32'(got.short_beep));
					check_field("long_beep", 32'(want.long_beep), 32'(got.long_beep));
				end
			end
			if (s_tvalid && s_tready)
				expected_ticks.push_back(tick_button(s_tdata[0]));
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (pin_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= IN_TDATA_W'(pin_samples.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result ready, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			IDX_ACTIVE_LEVEL:   act_cfg = val[0];
			IDX_LEVEL_COUNT:    lvl_count_cfg = val[2:0];
			IDX_THR_ONE:        thr_cfg[0] = val;
			IDX_THR_TWO:        thr_cfg[1] = val;
			IDX_THR_THREE:      thr_cfg[2] = val;
			IDX_THR_FOUR:       thr_cfg[3] = val;
			IDX_THR_FIVE:       thr_cfg[4] = val;
			IDX_ALARM_INTERVAL: alarm_cfg = val[GAP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic add_run(input logic is_pressed, input int unsigned n);
		repeat (n)
			pin_samples.push_back(is_pressed ? act_cfg : ~act_cfg);
	endtask

	task automatic drain();
		while (pin_samples.size() != 0 || s_tvalid || expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] thr_val [NUM_THRESH];
		logic [CFG_W-1:0] step;
		int unsigned      count;
		int unsigned      plen;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset settings, active low
		pin_samples.push_back(1'b1);
		pin_samples.push_back(1'b0);
		pin_samples.push_back(1'b0);
		pin_samples.push_back(1'b1);
		drain();

		write_reg(IDX_ACTIVE_LEVEL, {23'($urandom_range(8388607)), 1'b1});
		write_reg(IDX_LEVEL_COUNT, 24'd3);
		write_reg(IDX_THR_ONE, 24'd0);
		write_reg(IDX_THR_TWO, 24'd2);
		write_reg(IDX_THR_THREE, 24'd4);
		write_reg(IDX_THR_FOUR, 24'd6);
		write_reg(IDX_THR_FIVE, 24'd8);
		write_reg(IDX_ALARM_INTERVAL, 24'd2);
		add_run(1'b0, 2);
		add_run(1'b1, 8);
		add_run(1'b0, 2);
		add_run(1'b1, 1);
		add_run(1'b0, 1);
		drain();

		// no thresholds in use: max on the first held tick
		write_reg(IDX_LEVEL_COUNT, 24'd0);
		add_run(1'b1, 3);
		add_run(1'b0, 1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			step = CFG_W'($urandom_range(4));
			for (int i = 0; i < NUM_THRESH; i++) begin
				if (p == 2)
					thr_val[i] = CFG_W'($urandom_range(40));
				else begin
					thr_val[i] = step;
					step = step + CFG_W'($urandom_range(1, 9));
				end
			end
			if (p == 4) begin
				thr_val[0] = '0;
				thr_val[4] = '1;
			end
			write_reg(IDX_ACTIVE_LEVEL, {23'($urandom_range(8388607)), 1'(p % 2)});
			case (p)
				0: write_reg(IDX_LEVEL_COUNT, 24'd5);
				1: write_reg(IDX_LEVEL_COUNT, 24'd7);
				2: write_reg(IDX_LEVEL_COUNT, 24'd2);
				3: write_reg(IDX_LEVEL_COUNT, 24'd1);
				4: write_reg(IDX_LEVEL_COUNT, 24'd4);
				default: write_reg(IDX_LEVEL_COUNT, 24'd6);
			endcase
			write_reg(IDX_THR_ONE, thr_val[0]);
			write_reg(IDX_THR_TWO, thr_val[1]);
			write_reg(IDX_THR_THREE, thr_val[2]);
			write_reg(IDX_THR_FOUR, thr_val[3]);
			write_reg(IDX_THR_FIVE, thr_val[4]);
			case (p)
				0: write_reg(IDX_ALARM_INTERVAL, 24'd1);
				1: write_reg(IDX_ALARM_INTERVAL, 24'd0);
				2: write_reg(IDX_ALARM_INTERVAL, 24'd3);
				3: write_reg(IDX_ALARM_INTERVAL, 24'hFFFF);
				4: write_reg(IDX_ALARM_INTERVAL, CFG_W'($urandom_range(2, 15)));
				default: write_reg(IDX_ALARM_INTERVAL, CFG_W'($urandom_range(1, 8)));
			endcase

			count = 0;
			while (count < 120) begin
				if ($urandom_range(9) < 8) begin
					plen = ($urandom_range(9) < 7) ? $urandom_range(1, 15) : $urandom_range(16, 70);
					add_run(1'b1, plen);
					add_run(1'b0, $urandom_range(1, 4));
					count += plen + 1;
				end else begin
					pin_samples.push_back(1'($urandom_range(1)));
					count++;
				end
			end
			if (p == 2) begin
				@(posedge clk);
				hold_reqs++;
			end
			drain();
		end

		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/blpld_pkg.sv
rtl/blpld_track.sv
rtl/button_long_press_level_detector.sv
tb/button_long_press_level_detector_tb.sv
